// ===== hw/rtl/pqpw_pkg.sv =====
`default_nettype none

package pqpw_pkg;

	// panel geometry
	localparam int PANEL_WIDTH  = 640;
	localparam int PANEL_HEIGHT = 400;
	localparam int PIXELS       = PANEL_WIDTH * PANEL_HEIGHT;
	localparam int STORE_BYTES  = (PIXELS + 1) / 2;
	localparam int ADDR_W       = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int PIX_W        = $clog2(PIXELS);

	// field widths
	localparam int COORD_W  = 12;
	localparam int CHAN_W   = 8;
	localparam int RADDR_W  = 17;
	localparam int IDX_W    = 3;
	localparam int NIB_W    = 4;
	localparam int BYTE_W   = 2 * NIB_W;
	localparam int SQ_W     = 2 * CHAN_W;
	localparam int DIST_W   = SQ_W + 2;

	localparam int PAL_SIZE = 7;
	localparam int NUM_CH   = 3;

	localparam logic [NIB_W-1:0] WHITE_NIB = 4'h1;

	// decoupling queue
	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// palette, R G B per entry: black white green blue red yellow orange
	localparam logic [CHAN_W-1:0] PALETTE [PAL_SIZE][NUM_CH] = '{
		'{8'd57,  8'd48,  8'd57},
		'{8'd255, 8'd255, 8'd255},
		'{8'd58,  8'd91,  8'd70},
		'{8'd61,  8'd59,  8'd94},
		'{8'd156, 8'd72,  8'd75},
		'{8'd208, 8'd190, 8'd71},
		'{8'd177, 8'd106, 8'd73}
	};

	// square lookup for an 8-bit magnitude
	typedef logic [SQ_W-1:0] sq_tab_t [256];

	function automatic sq_tab_t build_sq_tab();
		sq_tab_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = SQ_W'(i * i);
		end
		return t;
	endfunction

	localparam sq_tab_t SQ_TAB = build_sq_tab();

	// classified request handed from front to back
	typedef struct packed {
		logic              is_read;
		logic              drawn;    // draw on panel, store it
		logic [IDX_W-1:0]  pal_idx;  // zero unless drawn
		logic              odd;      // odd pixel -> low nibble
		logic              addr_ok;  // read address inside store
		logic [ADDR_W-1:0] addr;
	} pqpw_job_t;

	typedef struct packed {
		logic      valid;
		pqpw_job_t job;
	} pqpw_slot_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pqpw_front.sv =====
`default_nettype none

module pqpw_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              req_type,
	input  wire logic signed [pqpw_pkg::COORD_W-1:0] x_coord,
	input  wire logic signed [pqpw_pkg::COORD_W-1:0] y_coord,
	input  wire logic [pqpw_pkg::CHAN_W-1:0]       red,
	input  wire logic [pqpw_pkg::CHAN_W-1:0]       green,
	input  wire logic [pqpw_pkg::CHAN_W-1:0]       blue,
	input  wire logic [pqpw_pkg::RADDR_W-1:0]      read_address,
	input  wire logic                              clearing,
	input  wire logic                              q_full,
	output pqpw_pkg::pqpw_slot_t                   out_slot
);
	import pqpw_pkg::*;

	logic adv;
	logic accept;
	logic x_ok;
	logic y_ok;
	logic [PIX_W-1:0] pix_c;
	logic [CHAN_W-1:0] col_c [NUM_CH];
	logic [CHAN_W-1:0] ad_c [PAL_SIZE][NUM_CH];
	pqpw_job_t job_c;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	pqpw_job_t job_s1, job_s2, job_s3, job_s4;
	logic [SQ_W-1:0] sq_s1 [PAL_SIZE][NUM_CH];
	logic [DIST_W-1:0] dist_s2 [PAL_SIZE];
	logic [DIST_W-1:0] cdist_s3 [4];
	logic [IDX_W-1:0] cidx_s3 [4];

	logic [DIST_W-1:0] cd_c [4];
	logic [IDX_W-1:0] ci_c [4];
	logic [DIST_W-1:0] da_c, db_c;
	logic [IDX_W-1:0] ia_c, ib_c, best_c;
	pqpw_job_t job_fin_c;

	// whole pipeline stalls only when the last stage cannot drain
	assign adv      = !(valid_s4 && q_full);
	assign in_ready = adv && !clearing;
	assign accept   = in_valid && in_ready;

	assign x_ok  = !x_coord[COORD_W-1] &&
		({1'b0, x_coord[COORD_W-2:0]} < COORD_W'(PANEL_WIDTH));
	assign y_ok  = !y_coord[COORD_W-1] &&
		({1'b0, y_coord[COORD_W-2:0]} < COORD_W'(PANEL_HEIGHT));
	assign pix_c = PIX_W'(y_coord[COORD_W-2:0]) * PIX_W'(PANEL_WIDTH)
		+ PIX_W'(x_coord[COORD_W-2:0]);

	assign col_c[0] = red;
	assign col_c[1] = green;
	assign col_c[2] = blue;

	always_comb begin
		for (int k = 0; k < PAL_SIZE; k++) begin
			for (int c = 0; c < NUM_CH; c++) begin
				ad_c[k][c] = (col_c[c] >= PALETTE[k][c]) ? col_c[c] - PALETTE[k][c]
					: PALETTE[k][c] - col_c[c];
			end
		end
	end

	always_comb begin
		job_c         = '0;
		job_c.is_read = req_type;
		job_c.pal_idx = '0;
		if (req_type) begin
			job_c.addr    = ADDR_W'(read_address);
			job_c.addr_ok = ({15'd0, read_address} < 32'(STORE_BYTES));
		end else begin
			job_c.drawn = x_ok && y_ok;
			job_c.odd   = pix_c[0];
			job_c.addr  = ADDR_W'(pix_c >> 1);
		end
	end

	// pairwise minimum, lower entry wins ties
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (dist_s2[2*j+1] < dist_s2[2*j]) begin
				cd_c[j] = dist_s2[2*j+1];
				ci_c[j] = IDX_W'(2*j+1);
			end else begin
				cd_c[j] = dist_s2[2*j];
				ci_c[j] = IDX_W'(2*j);
			end
		end
		cd_c[3] = dist_s2[6];
		ci_c[3] = IDX_W'(6);
	end

	always_comb begin
		if (cdist_s3[1] < cdist_s3[0]) begin
			da_c = cdist_s3[1];
			ia_c = cidx_s3[1];
		end else begin
			da_c = cdist_s3[0];
			ia_c = cidx_s3[0];
		end
		if (cdist_s3[3] < cdist_s3[2]) begin
			db_c = cdist_s3[3];
			ib_c = cidx_s3[3];
		end else begin
			db_c = cdist_s3[2];
			ib_c = cidx_s3[2];
		end
		best_c = (db_c < da_c) ? ib_c : ia_c;
	end

	// index only kept for a stored draw
	always_comb begin
		job_fin_c         = job_s3;
		job_fin_c.pal_idx = job_s3.drawn ? best_c : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			job_s1 <= job_c;
			for (int k = 0; k < PAL_SIZE; k++) begin
				for (int c = 0; c < NUM_CH; c++) begin
					sq_s1[k][c] <= SQ_TAB[ad_c[k][c]];
				end
			end
			job_s2 <= job_s1;
			for (int k = 0; k < PAL_SIZE; k++) begin
				dist_s2[k] <= DIST_W'(sq_s1[k][0]) + DIST_W'(sq_s1[k][1])
					+ DIST_W'(sq_s1[k][2]);
			end
			job_s3 <= job_s2;
			for (int j = 0; j < 4; j++) begin
				cdist_s3[j] <= cd_c[j];
				cidx_s3[j]  <= ci_c[j];
			end
			job_s4 <= job_fin_c;
		end
	end

	assign out_slot.valid = valid_s4;
	assign out_slot.job   = job_s4;

endmodule

`default_nettype wire

// ===== hw/rtl/pqpw_queue.sv =====
`default_nettype none

module pqpw_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  pqpw_pkg::pqpw_slot_t push_slot,
	output logic                full,
	input  wire logic           pop,
	output pqpw_pkg::pqpw_slot_t head
);
	import pqpw_pkg::*;

	pqpw_job_t entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic push;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign push       = push_slot.valid && !full;
	assign head.valid = (count_q != '0);
	assign head.job   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_slot.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue popped while empty");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("queue count missed a push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("queue count missed a pop");

endmodule

`default_nettype wire

// ===== hw/rtl/pqpw_back.sv =====
`default_nettype none

module pqpw_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  pqpw_pkg::pqpw_slot_t               head,
	output logic                               pop,
	output logic                               clearing,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [pqpw_pkg::IDX_W-1:0]         palette_index,
	output logic                               drawn,
	output logic [pqpw_pkg::BYTE_W-1:0]        read_byte
);
	import pqpw_pkg::*;

	typedef enum logic [1:0] {ST_CLEAR, ST_RUN, ST_READ} state_t;

	state_t state_q;
	logic [ADDR_W-1:0] clr_q;
	logic out_valid_q;
	logic [IDX_W-1:0] idx_q;
	logic drawn_q;
	logic [BYTE_W-1:0] byte_q;
	logic rd_ok_q;

	// high nibble = even pixel, low nibble = odd pixel
	logic [NIB_W-1:0] hi_mem [STORE_BYTES];
	logic [NIB_W-1:0] lo_mem [STORE_BYTES];
	logic [NIB_W-1:0] rd_hi_q, rd_lo_q;

	logic slot_free;
	logic do_write;
	logic out_set;
	logic we_hi, we_lo;
	logic [ADDR_W-1:0] waddr;
	logic [NIB_W-1:0] wdata;

	assign clearing  = (state_q == ST_CLEAR);
	assign slot_free = !out_valid_q || out_ready;
	assign pop       = (state_q == ST_RUN) && head.valid && slot_free;
	assign do_write  = pop && !head.job.is_read && head.job.drawn;
	// result register loads for a popped draw, or in ST_READ for a read
	assign out_set   = (state_q == ST_READ) || (pop && !head.job.is_read);
	assign we_hi     = clearing || (do_write && !head.job.odd);
	assign we_lo     = clearing || (do_write && head.job.odd);
	assign waddr     = clearing ? clr_q : head.job.addr;
	assign wdata     = clearing ? WHITE_NIB : NIB_W'(head.job.pal_idx);

	always_ff @(posedge clk) begin
		if (we_hi) begin
			hi_mem[waddr] <= wdata;
		end
		rd_hi_q <= hi_mem[head.job.addr];
	end

	always_ff @(posedge clk) begin
		if (we_lo) begin
			lo_mem[waddr] <= wdata;
		end
		rd_lo_q <= lo_mem[head.job.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			drawn_q     <= 1'b0;
			byte_q      <= '0;
			rd_ok_q     <= 1'b0;
		end else begin
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (clr_q == ADDR_W'(STORE_BYTES - 1)) begin
						state_q <= ST_RUN;
					end else begin
						clr_q <= clr_q + ADDR_W'(1);
					end
				end
				ST_RUN: begin
					if (pop) begin
						if (head.job.is_read) begin
							state_q <= ST_READ;
							rd_ok_q <= head.job.addr_ok;
						end else begin
							idx_q       <= head.job.pal_idx;
							drawn_q     <= head.job.drawn;
							byte_q      <= '0;
						end
					end
				end
				ST_READ: begin
					idx_q       <= '0;
					drawn_q     <= 1'b0;
					byte_q      <= rd_ok_q ? {rd_hi_q, rd_lo_q} : '0;
					state_q     <= ST_RUN;
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign palette_index = idx_q;
	assign drawn         = drawn_q;
	assign read_byte     = byte_q;

	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> !out_valid_q)
		else $error("read data would overwrite a pending result");

	a_one_nibble: assert property (@(posedge clk) disable iff (!arst_n)
		(we_hi && we_lo) |-> clearing)
		else $error("draw wrote both nibbles");

	a_draw_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && drawn_q) |-> byte_q == '0)
		else $error("draw result carries read data");

	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !out_valid_q)
		else $error("result produced during clear pass");

endmodule

`default_nettype wire

// ===== hw/rtl/palette_quantizing_pixel_writer.sv =====
// Channel  Dir  Handshake          Content
// s_*      in   s_tvalid/s_tready  draw or read request, s_tuser = req_type
// m_*      out  m_tvalid/m_tready  one result per request
//
// After reset the frame store is swept to white, one byte per cycle, over
// all STORE_BYTES bytes (128000 at 640x400) with s_tready held low.
// The front accepts one item per cycle unless the queue is full, through a
// 4-stage pipeline that does the bounds check, pixel address multiply and
// the nearest-palette search. The back ends a draw in ST_RUN, a read in
// ST_READ (registered RAM read port); a 4-entry queue absorbs the gap.
// m_tready low fills the output register, then the queue, then stalls input.
`default_nettype none

module palette_quantizing_pixel_writer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// x_coord[11:0] y_coord[23:12] red[31:24] green[39:32] blue[47:40]
	// read_address[64:48], zero pad [71:65]
	input  wire logic [71:0] s_tdata,
	// req_type[0]
	input  wire logic [0:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// palette_index[2:0] drawn[3] read_byte[11:4], zero pad [15:12]
	output logic [15:0]      m_tdata
);
	import pqpw_pkg::*;

	logic signed [COORD_W-1:0] x_coord, y_coord;
	logic [CHAN_W-1:0] red, green, blue;
	logic [RADDR_W-1:0] read_address;

	pqpw_slot_t front_slot;
	pqpw_slot_t head_slot;
	logic q_full;
	logic pop;
	logic clearing;

	logic [IDX_W-1:0] palette_index;
	logic drawn;
	logic [BYTE_W-1:0] read_byte;

	assign x_coord      = s_tdata[11:0];
	assign y_coord      = s_tdata[23:12];
	assign red          = s_tdata[31:24];
	assign green        = s_tdata[39:32];
	assign blue         = s_tdata[47:40];
	assign read_address = s_tdata[64:48];

	// classify, address, nearest palette entry
	pqpw_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.req_type     (s_tuser[0]),
		.x_coord      (x_coord),
		.y_coord      (y_coord),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.read_address (read_address),
		.clearing     (clearing),
		.q_full       (q_full),
		.out_slot     (front_slot)
	);

	pqpw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_slot (front_slot),
		.full      (q_full),
		.pop       (pop),
		.head      (head_slot)
	);

	// frame store access and result register
	pqpw_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head_slot),
		.pop           (pop),
		.clearing      (clearing),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.palette_index (palette_index),
		.drawn         (drawn),
		.read_byte     (read_byte)
	);

	assign m_tdata = {4'b0000, read_byte, drawn, palette_index};

endmodule

`default_nettype wire
